FILE: design/whole_word_match_counter_macros.svh
// ----------------------------------------------------------------------------
// Whole-word match counter assertion macros
// Concurrent assertion shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WHOLE_WORD_MATCH_COUNTER_MACROS_SVH
`define WHOLE_WORD_MATCH_COUNTER_MACROS_SVH

// Same-cycle implication.
`define WWMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WWMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wwmc_pkg.sv
// ----------------------------------------------------------------------------
// Whole-word match counter package
// Shared payload types, register codes and byte helpers.
// ----------------------------------------------------------------------------
package wwmc_pkg;

    localparam int MAX_WORD_DEFAULT = 24;
    localparam int CHARS_PER_REG    = 8;
    localparam int LEN_W            = 5;
    localparam int COUNT_W          = 32;
    localparam int CFG_DATA_W       = 64;

    typedef enum logic [1:0] {
        REG_CHARS_LOW  = 2'd0,
        REG_CHARS_MID  = 2'd1,
        REG_CHARS_HIGH = 2'd2,
        REG_LENGTH     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } text_item_t;

    typedef struct packed {
        logic               word_hit;
        logic [COUNT_W-1:0] match_count;
    } result_item_t;

    typedef struct packed {
        cfg_reg_t              index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    // Handshake control from the input register to the core
    typedef struct packed {
        logic item_valid;
        logic advance;
    } step_ctrl_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        lower_byte = (c >= 8'h41 && c <= 8'h5A) ? (c + 8'h20) : c;
    endfunction

    function automatic logic is_letter_byte(input logic [7:0] c);
        is_letter_byte = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_space_byte(input logic [7:0] c);
        is_space_byte = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

FILE: design/wwmc_chan_if.sv
// ----------------------------------------------------------------------------
// Whole-word match counter channel interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface wwmc_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/whole_word_match_counter.sv
// ----------------------------------------------------------------------------
// Whole-word match counter
// Counts case-insensitive occurrences of a target word in a byte stream.
// ----------------------------------------------------------------------------
// Feed text one byte per transaction on text_in; every byte yields exactly one
// transaction on result_out with word_hit (this byte closed a token whose first
// letter run equals the target word, case ignored) and match_count (saturating
// total including this hit). Whitespace closes a token; a byte marked is_last
// also closes its token and then clears the count for the next stream. The
// block sustains one byte per clock while result_out is ready: a byte is held in
// the input register, is evaluated by the token core and lands in the result
// register, and a stalled result_out holds the pipeline only once both registers
// are full. Write the target word (lowest byte is the first character) and its
// length over cfg while no bytes are in flight; a length of zero or above
// MAX_WORD never hits.
// ----------------------------------------------------------------------------
module whole_word_match_counter
    import wwmc_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    wwmc_chan_if.sink   text_in,
    wwmc_chan_if.source result_out,
    wwmc_chan_if.sink   cfg
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    text_item_t in_item_reg, in_item_next;
    logic       in_accept;
    logic       advance;
    logic       res_valid;
    step_ctrl_t ctrl;

    logic [MAX_WORD-1:0][7:0] target_chars;
    logic [LEN_W-1:0]         target_length;

    // Advance the pipeline whenever the result register is empty or drains
    assign advance       = !res_valid || result_out.ready;
    assign text_in.ready = !in_valid_reg || advance;
    assign in_accept     = text_in.valid && text_in.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        // Take a new transaction into the emptied or draining input register
        if (in_accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = text_in.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    assign ctrl.item_valid = in_valid_reg;
    assign ctrl.advance    = advance;

    wwmc_cfg_regs #(
        .MAX_WORD (MAX_WORD)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .target_chars  (target_chars),
        .target_length (target_length)
    );

    wwmc_token_core #(
        .MAX_WORD (MAX_WORD)
    ) u_token_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .item          (in_item_reg),
        .target_chars  (target_chars),
        .target_length (target_length),
        .res_valid     (res_valid),
        .res_item      (result_out.payload)
    );

    assign result_out.valid = res_valid;

    // Assertions
    `include "whole_word_match_counter_macros.svh"

    // A hit always shows a nonzero running count
    `WWMC_ASSERT_NOW(a_hit_count_nonzero, result_out.valid && result_out.payload.word_hit,
        result_out.payload.match_count != '0, "hit reported with zero match count")

    // A byte stuck behind a stalled result stays in the input register
    `WWMC_ASSERT_NEXT(a_input_held, in_valid_reg && !advance,
        in_valid_reg, "input transaction dropped while stalled")

    // A full input register takes a new byte only while the pipeline advances
    `WWMC_ASSERT_NOW(a_no_overwrite, in_accept && in_valid_reg,
        advance, "input register overwritten")

    // Advancing a held byte always fills the result register
    `WWMC_ASSERT_NEXT(a_result_filled, in_valid_reg && advance,
        result_out.valid, "result lost after advance")

endmodule

FILE: design/wwmc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Whole-word match counter configuration registers
// Target word storage, lowercased on write, and target length.
// ----------------------------------------------------------------------------
module wwmc_cfg_regs
    import wwmc_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    wwmc_chan_if.sink                  cfg,
    output logic [MAX_WORD-1:0][7:0]   target_chars,
    output logic [LEN_W-1:0]           target_length
);

    logic                     wr_en;
    logic [MAX_WORD-1:0][7:0] chars_reg;
    logic [LEN_W-1:0]         length_reg;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    for (genvar i = 0; i < MAX_WORD; i++) begin : g_char
        localparam cfg_reg_t SEL   = cfg_reg_t'(i / CHARS_PER_REG);
        localparam int       SLICE = (i % CHARS_PER_REG) * 8;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                chars_reg[i] <= 8'h00;
            end
            else if (wr_en && cfg.payload.index == SEL)
            begin
                chars_reg[i] <= lower_byte(cfg.payload.data[SLICE +: 8]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (wr_en && cfg.payload.index == REG_LENGTH)
        begin
            length_reg <= cfg.payload.data[LEN_W-1:0];
        end
    end

    assign target_chars  = chars_reg;
    assign target_length = length_reg;

endmodule

FILE: design/wwmc_token_core.sv
// ----------------------------------------------------------------------------
// Whole-word match counter token core
// Per-byte token tracking, word compare, saturating count, result register.
// ----------------------------------------------------------------------------
module wwmc_token_core
    import wwmc_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  step_ctrl_t               ctrl,
    input  text_item_t               item,
    input  logic [MAX_WORD-1:0][7:0] target_chars,
    input  logic [LEN_W-1:0]         target_length,
    output logic                     res_valid,
    output result_item_t             res_item
);

    localparam int POS_W = $clog2(MAX_WORD + 1);
    localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    typedef enum logic [3:0] {
        PH_BETWEEN = 4'b0001,
        PH_BEFORE  = 4'b0010,
        PH_LETTERS = 4'b0100,
        PH_AFTER   = 4'b1000
    } phase_t;

    phase_t             phase_reg, phase_next, phase_work;
    logic [POS_W-1:0]   pos_reg, pos_next, pos_work;
    logic               mism_reg, mism_next, mism_work;
    logic [COUNT_W-1:0] count_reg, count_next, count_work;
    logic               res_valid_reg, res_valid_next;
    result_item_t       res_item_reg, res_item_next;

    logic               step;
    logic               space_c;
    logic               letter_c;
    logic               pos_full;
    logic               close;
    logic               hit;

    assign step     = ctrl.item_valid && ctrl.advance;
    assign space_c  = is_space_byte(item.text_byte);
    assign letter_c = is_letter_byte(item.text_byte);
    assign pos_full = (LEN_W'(pos_reg) >= target_length) || (pos_reg == POS_W'(MAX_WORD));

    always_comb
    begin
        phase_work = phase_reg;
        pos_work   = pos_reg;
        mism_work  = mism_reg;
        close      = 1'b0;
        if (space_c)
        begin
            close = (phase_reg != PH_BETWEEN);
        end
        else
        begin
            if (phase_work == PH_BETWEEN)
            begin
                phase_work = PH_BEFORE;
            end
            if (letter_c)
            begin
                if (phase_work == PH_BEFORE)
                begin
                    phase_work = PH_LETTERS;
                end
                if (phase_work == PH_LETTERS)
                begin
                    if (pos_full)
                    begin
                        mism_work = 1'b1;
                    end
                    else
                    begin
                        if (lower_byte(item.text_byte) != target_chars[pos_reg[IDX_W-1:0]])
                        begin
                            mism_work = 1'b1;
                        end
                        pos_work = pos_reg + POS_W'(1);
                    end
                end
            end
            else if (phase_work == PH_LETTERS)
            begin
                phase_work = PH_AFTER;
            end
            if (item.is_last)
            begin
                close = 1'b1;
            end
        end

        hit = close && (phase_work == PH_LETTERS || phase_work == PH_AFTER) && !mism_work
            && (target_length != '0) && (target_length <= LEN_W'(MAX_WORD))
            && (LEN_W'(pos_work) == target_length);

        count_work = (hit && count_reg != '1) ? count_reg + COUNT_W'(1) : count_reg;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        mism_next      = mism_reg;
        count_next     = count_reg;
        res_item_next  = res_item_reg;
        res_valid_next = res_valid_reg;
        if (ctrl.advance)
        begin
            res_valid_next = ctrl.item_valid;
        end
        if (step)
        begin
            res_item_next.word_hit    = hit;
            res_item_next.match_count = count_work;
            if (close || item.is_last)
            begin
                phase_next = PH_BETWEEN;
                pos_next   = '0;
                mism_next  = 1'b0;
            end
            else
            begin
                phase_next = phase_work;
                pos_next   = pos_work;
                mism_next  = mism_work;
            end
            count_next = item.is_last ? '0 : count_work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BETWEEN;
            pos_reg       <= '0;
            mism_reg      <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            mism_reg      <= mism_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whole-word match counter testbench
// Streams text bytes through the counter under random source gaps and sink
// stalls, scores every byte against a local token tracker and compares each
// result transaction, field by field, with the oldest scored tally.
// ----------------------------------------------------------------------------
module tb_top;
    import wwmc_pkg::*;

    localparam int WORD_MAX      = MAX_WORD_DEFAULT;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BYTES   = 70;
    localparam int RANDOM_PHASES = 11;
    localparam int DRAIN_CYCLES  = 8;

    // Where the tracker stands inside the current token
    typedef enum logic [1:0] {
        SEG_OUTSIDE  = 2'd0,
        SEG_LEADING  = 2'd1,
        SEG_LETTERS  = 2'd2,
        SEG_TRAILING = 2'd3
    } seg_phase_t;

    logic clk;
    logic rst_n;

    wwmc_chan_if #(.payload_t(text_item_t))   text_if ();
    wwmc_chan_if #(.payload_t(result_item_t)) result_if ();
    wwmc_chan_if #(.payload_t(cfg_write_t))   cfg_if ();

    whole_word_match_counter #(
        .MAX_WORD(WORD_MAX)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    // Local copy of the target registers, updated on each accepted write
    logic [63:0] shadow_chars [0:2];
    logic [4:0]  shadow_len;

    // Token tracker state
    seg_phase_t  seg;
    logic [4:0]  word_len;
    logic        differs;
    logic [31:0] hits_total;

    text_item_t   text_backlog [$];   // bytes waiting for the driver
    cfg_write_t   target_writes [$];  // register writes waiting for the cfg driver
    result_item_t tallies_due [$];    // scored results, oldest first

    // Target the generator aims its words at
    logic [7:0] plan_chars [0:23];
    int         plan_len;

    bit src_gaps;
    bit sink_stalls;
    bit src_busy;
    bit cfg_busy;
    int src_wait;
    int sink_wait;
    int fault_count = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------------
    // Byte classes, written independently of the package helpers
    // ------------------------------------------------------------------------
    function automatic logic is_alpha(input logic [7:0] c);
        logic [7:0] f;
        f = c | 8'h20;
        return (f >= 8'h61) && (f <= 8'h7A);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return is_alpha(c) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] target_at(input logic [4:0] pos);
        return fold(shadow_chars[pos >> 3][{pos[2:0], 3'b000} +: 8]);
    endfunction

    // ------------------------------------------------------------------------
    // Score one accepted byte: advance the token tracker, return hit and count
    // ------------------------------------------------------------------------
    function automatic result_item_t tally_byte(input text_item_t item);
        logic [7:0]   c;
        logic         closing;
        result_item_t res;
        c            = item.text_byte;
        closing      = 1'b0;
        res.word_hit = 1'b0;
        if (is_blank(c)) begin
            closing = (seg != SEG_OUTSIDE);
        end
        else begin
            if (seg == SEG_OUTSIDE)
                seg = SEG_LEADING;
            if (is_alpha(c)) begin
                if (seg == SEG_LEADING)
                    seg = SEG_LETTERS;
                if (seg == SEG_LETTERS) begin
                    // a letter past the target length spoils the word; the
                    // position counter stops growing there
                    if (word_len >= shadow_len || word_len >= WORD_MAX) begin
                        differs = 1'b1;
                    end
                    else begin
                        if (fold(c) != target_at(word_len))
                            differs = 1'b1;
                        word_len = word_len + 5'd1;
                    end
                end
            end
            else if (seg == SEG_LETTERS) begin
                seg = SEG_TRAILING;
            end
            if (item.is_last)
                closing = 1'b1;
        end
        if (closing) begin
            if ((seg == SEG_LETTERS || seg == SEG_TRAILING) && !differs &&
                shadow_len != 5'd0 && shadow_len <= WORD_MAX && word_len == shadow_len) begin
                res.word_hit = 1'b1;
                if (hits_total != 32'hFFFF_FFFF)
                    hits_total = hits_total + 32'd1;
            end
            seg      = SEG_OUTSIDE;
            word_len = '0;
            differs  = 1'b0;
        end
        res.match_count = hits_total;
        // the stream ends here: drop the token and restart the count
        if (item.is_last) begin
            seg        = SEG_OUTSIDE;
            word_len   = '0;
            differs    = 1'b0;
            hits_total = '0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Byte generators
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
    endfunction

    // Spaces come up more often than the other separators
    function automatic logic [7:0] rand_blank();
        int r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? 8'h20 : (8'h09 + 8'(r));
    endfunction

    // Any byte that is neither a letter nor whitespace, high bytes included
    function automatic logic [7:0] any_mark();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_alpha(c) || is_blank(c));
        return c;
    endfunction

    function automatic logic [7:0] vary_case(input logic [7:0] c);
        if (!is_alpha(c))
            return c;
        return $urandom_range(0, 1) ? (c & 8'hDF) : (c | 8'h20);
    endfunction

    // Replace a letter by a different one, keeping the case random
    function automatic logic [7:0] swap_letter(input logic [7:0] c);
        int k;
        if (!is_alpha(c))
            return rand_letter();
        k = (fold(c) - 8'h61 + $urandom_range(1, 25)) % 26;
        return vary_case(8'h61 + 8'(k));
    endfunction

    task automatic add_byte(input logic [7:0] c, input logic last);
        text_backlog.push_back(text_item_t'{c, last});
    endtask

    task automatic add_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // ------------------------------------------------------------------------
    // Build one token with its separator and queue it. Most tokens are the
    // target word or a close miss; the rest are random letters or raw noise.
    // ------------------------------------------------------------------------
    task automatic add_token(input int kind, output int added);
        text_item_t tok [$];
        text_item_t tail;
        int         span;
        int         n;
        int         pos;
        int         r;
        logic [7:0] c;
        span = (plan_len > WORD_MAX) ? WORD_MAX : plan_len;
        pos  = -1;
        // leading junk before the letters
        if (kind != 9 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) tok.push_back(text_item_t'{any_mark(), 1'b0});
        if (kind <= 8) begin
            case (kind)
                5: n = (span > 1) ? $urandom_range(1, span - 1) : $urandom_range(1, 3);
                6: n = span + $urandom_range(1, (span == WORD_MAX) ? 6 : 3);
                8: begin
                    n    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 30)
                                                         : $urandom_range(1, 8);
                    span = 0;
                end
                default: n = (span == 0) ? $urandom_range(1, 4) : span;
            endcase
            if (kind == 7)
                pos = $urandom_range(0, n - 1);
            for (int i = 0; i < n; i++) begin
                c = (i < span) ? vary_case(plan_chars[i]) : rand_letter();
                if (i == pos)
                    c = swap_letter(c);
                tok.push_back(text_item_t'{c, 1'b0});
            end
            // trailing junk, sometimes followed by more letters
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 2)) tok.push_back(text_item_t'{any_mark(), 1'b0});
                repeat ($urandom_range(0, 3)) tok.push_back(text_item_t'{rand_letter(), 1'b0});
            end
        end
        else begin
            repeat ($urandom_range(1, 5))
                tok.push_back(text_item_t'{8'($urandom_range(0, 255)),
                                           1'($urandom_range(0, 15) == 0)});
        end
        // close the token: end the stream on it, on a separator, or just separate
        r = $urandom_range(0, 11);
        if (r == 0) begin
            tail         = tok.pop_back();
            tail.is_last = 1'b1;
            tok.push_back(tail);
        end
        else if (r == 1) begin
            tok.push_back(text_item_t'{rand_blank(), 1'b1});
        end
        else begin
            repeat ((r == 2) ? 2 : 1) tok.push_back(text_item_t'{rand_blank(), 1'b0});
        end
        foreach (tok[i])
            text_backlog.push_back(tok[i]);
        added = tok.size();
    endtask

    // Hold until no byte, result or register write is in flight
    task automatic wait_idle();
        do
            @(negedge clk);
        while (text_backlog.size() != 0 || text_if.valid || tallies_due.size() != 0 ||
               target_writes.size() != 0 || cfg_if.valid);
    endtask

    // Pack plan_chars into the three character registers and write all four
    task automatic load_target(input logic [63:0] len_data);
        logic [63:0] packed_chars [0:2];
        wait_idle();
        for (int i = 0; i < WORD_MAX; i++)
            packed_chars[i / 8][(i % 8) * 8 +: 8] = plan_chars[i];
        plan_len = len_data[4:0];
        target_writes.push_back(cfg_write_t'{REG_CHARS_LOW,  packed_chars[0]});
        target_writes.push_back(cfg_write_t'{REG_CHARS_MID,  packed_chars[1]});
        target_writes.push_back(cfg_write_t'{REG_CHARS_HIGH, packed_chars[2]});
        target_writes.push_back(cfg_write_t'{REG_LENGTH,     len_data});
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold reset, then release it for good; the drivers clear their own outputs
    // while reset is low.
    initial begin
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Text driver: present backlog bytes one per transaction, idle a random
    // number of cycles before each when gaps are on, and score every byte at
    // the edge that accepts it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            text_if.valid   <= 1'b0;
            text_if.payload <= '0;
            src_busy   = 1'b0;
            src_wait   = 0;
            seg        = SEG_OUTSIDE;
            word_len   = '0;
            differs    = 1'b0;
            hits_total = '0;
        end
        else begin
            if (text_if.valid && text_if.ready) begin
                tallies_due.push_back(tally_byte(text_if.payload));
                src_busy = 1'b0;
            end
            if (!src_busy) begin
                if (src_wait > 0) begin
                    src_wait = src_wait - 1;
                end
                else if (text_backlog.size() != 0) begin
                    text_if.payload <= text_backlog.pop_front();
                    src_busy = 1'b1;
                    src_wait = src_gaps ? $urandom_range(0, 9) : 0;
                end
            end
            // one assignment per edge keeps valid high across back-to-back bytes
            text_if.valid <= src_busy;
        end
    end

    // ------------------------------------------------------------------------
    // Register write driver: apply each accepted write to the shadow copy
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_if.valid   <= 1'b0;
            cfg_if.payload <= '0;
            cfg_busy        = 1'b0;
            shadow_chars[0] = '0;
            shadow_chars[1] = '0;
            shadow_chars[2] = '0;
            shadow_len      = '0;
        end
        else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.payload.index)
                    REG_CHARS_LOW:  shadow_chars[0] = cfg_if.payload.data;
                    REG_CHARS_MID:  shadow_chars[1] = cfg_if.payload.data;
                    REG_CHARS_HIGH: shadow_chars[2] = cfg_if.payload.data;
                    REG_LENGTH:     shadow_len      = cfg_if.payload.data[4:0];
                    default: ;
                endcase
                cfg_busy = 1'b0;
            end
            if (!cfg_busy && target_writes.size() != 0) begin
                cfg_if.payload <= target_writes.pop_front();
                cfg_busy = 1'b1;
            end
            cfg_if.valid <= cfg_busy;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each result transaction against the oldest tally,
    // then drop ready for a random stall when stalls are on.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : result_watch
        result_item_t want;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            sink_wait = 0;
        end
        else begin
            if (result_if.valid && result_if.ready) begin
                if (tallies_due.size() == 0) begin
                    $error("result with no byte pending: word_hit=%0d match_count=%0d",
                           result_if.payload.word_hit, result_if.payload.match_count);
                    fault_count++;
                end
                else begin
                    want = tallies_due.pop_front();
                    if (result_if.payload.word_hit !== want.word_hit) begin
                        $error("word_hit: expected %0d, got %0d",
                               want.word_hit, result_if.payload.word_hit);
                        fault_count++;
                    end
                    if (result_if.payload.match_count !== want.match_count) begin
                        $error("match_count: expected %0d, got %0d",
                               want.match_count, result_if.payload.match_count);
                        fault_count++;
                    end
                end
                sink_wait = sink_stalls ? $urandom_range(0, 9) : 0;
            end
            if (sink_wait > 0) begin
                sink_wait = sink_wait - 1;
                result_if.ready <= 1'b0;
            end
            else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus: directed bytes first, then random phases, each with its own
    // target word and its own mix of source gaps and sink stalls.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [63:0] len_data;
        int          want_len;
        int          produced;
        int          added;
        bit          paused;
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        plan_len    = 0;
        wait (rst_n);
        @(negedge clk);

        // Reset target has length zero: a closed word must not hit
        add_byte(8'hFF, 1'b0);
        add_text("a", 1'b0);
        add_byte(8'h00, 1'b1);
        wait_idle();

        // Target "CaT": the upper-case target bytes must fold to lower case
        for (int i = 0; i < WORD_MAX; i++)
            plan_chars[i] = 8'($urandom_range(0, 255));
        plan_chars[0] = 8'h43;
        plan_chars[1] = 8'h61;
        plan_chars[2] = 8'h54;
        len_data      = {$urandom, $urandom};
        len_data[4:0] = 5'd3;
        load_target(len_data);
        add_text("9Cat1x\t", 1'b0);   // junk before and letters after still hit
        add_text("ca", 1'b0);         // shorter word misses
        add_byte(8'h0B, 1'b0);
        add_text("cats", 1'b0);       // longer word misses
        add_byte(8'h0C, 1'b0);
        add_byte(8'h80, 1'b0);        // token without letters never hits
        add_byte(8'h7F, 1'b0);
        add_byte(8'h0D, 1'b0);
        add_text("Cat", 1'b1);        // last byte on a letter closes and hits
        add_text("cat", 1'b0);        // last byte on whitespace
        add_byte(8'h20, 1'b1);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            src_gaps    = (p % 3 != 0);
            sink_stalls = (p % 4 != 1);
            want_len    = $urandom_range(1, 5);
            case (p)
                0:       want_len = 31;
                1, 2:    want_len = 24;
                3:       want_len = 1;
                4:       want_len = 8;
                5:       want_len = 9;
                6:       want_len = 17;
                7:       want_len = $urandom_range(2, 6);
                8:       want_len = $urandom_range(25, 31);
                9:       want_len = 0;
                default: ;
            endcase
            for (int i = 0; i < WORD_MAX; i++)
                plan_chars[i] = (i < want_len) ? rand_letter() : 8'($urandom_range(0, 255));
            // all-ones and all-zero character registers can never match a letter
            if (p == 0)
                for (int i = 0; i < WORD_MAX; i++) plan_chars[i] = 8'hFF;
            if (p == 1)
                for (int i = 0; i < WORD_MAX; i++) plan_chars[i] = 8'h00;
            // a non-letter inside the target makes it unmatchable
            if (p == 7)
                plan_chars[$urandom_range(0, want_len - 1)] = any_mark();
            len_data      = {$urandom, $urandom};
            len_data[4:0] = want_len[4:0];
            if (p == 0)
                len_data = '1;
            load_target(len_data);

            produced = 0;
            paused   = 1'b0;
            while (produced < PHASE_BYTES) begin
                add_token($urandom_range(0, 9), added);
                produced += added;
                // stop feeding mid-phase now and then until every result is back
                if (!paused && produced >= PHASE_BYTES / 2 && $urandom_range(0, 1)) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        // Let the pipeline settle, then give the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tallies_due.size() != 0) begin
            $error("%0d results never arrived", tallies_due.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
